// ----- sv/tun_pkg.sv -----
// tun_pkg: widths, stage indexes and payload word types for the triangle normal unit
// depends on nothing; used by triangle_unit_normal_unit
package tun_pkg;

    // field widths
    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_BITS      = 16;

    // derived datapath widths
    localparam int EDGE_W  = COORD_BITS + 1;          // vertex difference
    localparam int PROD_W  = 2 * EDGE_W;              // edge component product
    localparam int CROSS_W = PROD_W + 1;              // cross product component
    localparam int MAG_W   = CROSS_W - 1;             // magnitude of a component
    localparam int SQ_W    = 2 * MAG_W;               // square of a component
    localparam int SUM_W   = SQ_W + 2;                // sum of three squares
    localparam int QW      = NORMAL_FRAC_BITS + 1;    // quotient bits
    localparam int T_W     = SUM_W + QW;              // running q * sum
    localparam int ACC_W   = T_W + 2 + NORMAL_FRAC_BITS; // remainder and step

    // pipeline stage indexes
    localparam int ST_EDGE  = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_CROSS = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_IT0   = 4;                       // sum of squares, first iteration input
    localparam int ST_OUT   = ST_IT0 + QW + 1;
    localparam int NST      = ST_OUT + 1;

    // input word
    typedef struct packed {
        logic signed [COORD_BITS-1:0] p0_x;
        logic signed [COORD_BITS-1:0] p0_y;
        logic signed [COORD_BITS-1:0] p0_z;
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p1_z;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] p2_z;
    } in_word_t;

    // result word
    typedef struct packed {
        logic signed [NORMAL_BITS-1:0] normal_x;
        logic signed [NORMAL_BITS-1:0] normal_y;
        logic signed [NORMAL_BITS-1:0] normal_z;
        logic                          degenerate;
    } out_word_t;

    // state carried through the square root / divide iterations
    typedef struct packed {
        logic [SUM_W-1:0]         s;
        logic                     deg;
        logic [2:0]               neg;
        logic [2:0][ACC_W-1:0]    r;
        logic [2:0][T_W-1:0]      t;
        logic [2:0][QW-1:0]       q;
    } iter_t;

endpackage

// ----- sv/triangle_unit_normal_unit.sv -----
// triangle_unit_normal_unit: streaming unit normal of a triangle, fully pipelined
// depends on tun_pkg (widths, stage indexes, word types)
//
// Usage:
//   s_valid/s_ready/s_data carry one triangle (three Q8.8 vertices) per word.
//   m_valid/m_ready/m_data carry the Q1.14 unit normal and a degenerate flag.
//   The edges p0-p1 and p1-p2 are crossed, the components squared and summed,
//   then each component is scaled by 2^14/sqrt(sum) in a restoring digit
//   loop, one quotient bit per pipeline stage (15 stages), then clamped to 1.0.
//   Throughput: one word per cycle while m_ready does not stall the output; every stage has its own valid bit.
//   Stall: when m_ready is low the output holds; upstream stages keep filling
//   empty slots, and s_ready drops only when every stage holds a word.
//   Reset: aresetn low (synchronous) empties the pipeline; no words are lost
//   or repeated across a stall.
//   A zero cross product gives a zero normal with degenerate set.
module triangle_unit_normal_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tun_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tun_pkg::out_word_t m_data
);

    localparam int F = tun_pkg::NORMAL_FRAC_BITS;

    logic [tun_pkg::NST-1:0] v_reg;
    logic [tun_pkg::NST-1:0] en;

    // stage registers
    logic signed [tun_pkg::EDGE_W-1:0]  e1_reg [3];
    logic signed [tun_pkg::EDGE_W-1:0]  e2_reg [3];
    logic signed [tun_pkg::PROD_W-1:0]  pa_reg [3];
    logic signed [tun_pkg::PROD_W-1:0]  pb_reg [3];
    logic signed [tun_pkg::CROSS_W-1:0] c_reg  [3];
    logic [tun_pkg::SQ_W-1:0]           sq_reg [3];
    logic [2:0]                         neg_reg;
    tun_pkg::iter_t                     it_reg  [tun_pkg::QW+1];
    tun_pkg::iter_t                     it_next [tun_pkg::QW];
    tun_pkg::out_word_t                 out_reg;

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        en[tun_pkg::NST-1] = !v_reg[tun_pkg::NST-1] || m_ready;
        for (int i = tun_pkg::NST - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[tun_pkg::NST-1];
    assign m_data  = out_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < tun_pkg::NST; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // edge vectors
    always_ff @(posedge aclk) begin
        if (en[tun_pkg::ST_EDGE]) begin
            e1_reg[0] <= {s_data.p0_x[tun_pkg::COORD_BITS-1], s_data.p0_x}
                       - {s_data.p1_x[tun_pkg::COORD_BITS-1], s_data.p1_x};
            e1_reg[1] <= {s_data.p0_y[tun_pkg::COORD_BITS-1], s_data.p0_y}
                       - {s_data.p1_y[tun_pkg::COORD_BITS-1], s_data.p1_y};
            e1_reg[2] <= {s_data.p0_z[tun_pkg::COORD_BITS-1], s_data.p0_z}
                       - {s_data.p1_z[tun_pkg::COORD_BITS-1], s_data.p1_z};
            e2_reg[0] <= {s_data.p1_x[tun_pkg::COORD_BITS-1], s_data.p1_x}
                       - {s_data.p2_x[tun_pkg::COORD_BITS-1], s_data.p2_x};
            e2_reg[1] <= {s_data.p1_y[tun_pkg::COORD_BITS-1], s_data.p1_y}
                       - {s_data.p2_y[tun_pkg::COORD_BITS-1], s_data.p2_y};
            e2_reg[2] <= {s_data.p1_z[tun_pkg::COORD_BITS-1], s_data.p1_z}
                       - {s_data.p2_z[tun_pkg::COORD_BITS-1], s_data.p2_z};
        end
    end

    // cross product partial products
    always_ff @(posedge aclk) begin
        if (en[tun_pkg::ST_PROD]) begin
            pa_reg[0] <= e1_reg[1] * e2_reg[2];
            pb_reg[0] <= e1_reg[2] * e2_reg[1];
            pa_reg[1] <= e1_reg[2] * e2_reg[0];
            pb_reg[1] <= e1_reg[0] * e2_reg[2];
            pa_reg[2] <= e1_reg[0] * e2_reg[1];
            pb_reg[2] <= e1_reg[1] * e2_reg[0];
        end
    end

    // cross product components
    always_ff @(posedge aclk) begin
        if (en[tun_pkg::ST_CROSS]) begin
            for (int j = 0; j < 3; j++) begin
                c_reg[j] <= {pa_reg[j][tun_pkg::PROD_W-1], pa_reg[j]}
                          - {pb_reg[j][tun_pkg::PROD_W-1], pb_reg[j]};
            end
        end
    end

    // magnitudes squared
    always_ff @(posedge aclk) begin
        logic [tun_pkg::CROSS_W-1:0] mag;
        if (en[tun_pkg::ST_SQ]) begin
            for (int j = 0; j < 3; j++) begin
                mag = c_reg[j][tun_pkg::CROSS_W-1] ? -c_reg[j] : c_reg[j];
                sq_reg[j]  <= tun_pkg::SQ_W'(mag[tun_pkg::MAG_W-1:0])
                            * tun_pkg::SQ_W'(mag[tun_pkg::MAG_W-1:0]);
                neg_reg[j] <= c_reg[j][tun_pkg::CROSS_W-1];
            end
        end
    end

    // sum of squares and loop seed
    always_ff @(posedge aclk) begin
        logic [tun_pkg::SUM_W-1:0] sum;
        if (en[tun_pkg::ST_IT0]) begin
            sum = tun_pkg::SUM_W'(sq_reg[0]) + tun_pkg::SUM_W'(sq_reg[1])
                + tun_pkg::SUM_W'(sq_reg[2]);
            it_reg[0].s   <= sum;
            it_reg[0].deg <= (sum == '0);
            it_reg[0].neg <= neg_reg;
            for (int j = 0; j < 3; j++) begin
                it_reg[0].r[j] <= tun_pkg::ACC_W'(sq_reg[j]) << (2 * F);
                it_reg[0].t[j] <= '0;
                it_reg[0].q[j] <= '0;
            end
        end
    end

    // one quotient bit per stage: take bit b when (2*q*S + S*2^b)*2^b fits the remainder
    for (genvar k = 0; k < tun_pkg::QW; k++) begin : g_iter
        localparam int B = F - k;

        always_comb begin
            logic [tun_pkg::ACC_W-1:0] sb;
            logic [tun_pkg::ACC_W-1:0] dl;
            it_next[k] = it_reg[k];
            sb = tun_pkg::ACC_W'(it_reg[k].s) << B;
            for (int j = 0; j < 3; j++) begin
                dl = ((tun_pkg::ACC_W'(it_reg[k].t[j]) << 1) + sb) << B;
                if (dl <= it_reg[k].r[j]) begin
                    it_next[k].r[j] = it_reg[k].r[j] - dl;
                    it_next[k].t[j] = it_reg[k].t[j] + sb[tun_pkg::T_W-1:0];
                    it_next[k].q[j] = it_reg[k].q[j] | (tun_pkg::QW'(1) << B);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[tun_pkg::ST_IT0 + 1 + k]) begin
                it_reg[k+1] <= it_next[k];
            end
        end
    end

    // clamp, sign and degenerate case
    always_ff @(posedge aclk) begin
        logic [tun_pkg::QW-1:0]          qc;
        logic [tun_pkg::NORMAL_BITS-1:0] val [3];
        if (en[tun_pkg::ST_OUT]) begin
            for (int j = 0; j < 3; j++) begin
                qc = (it_reg[tun_pkg::QW].q[j] > (tun_pkg::QW'(1) << F))
                   ? (tun_pkg::QW'(1) << F) : it_reg[tun_pkg::QW].q[j];
                val[j] = it_reg[tun_pkg::QW].neg[j]
                       ? -tun_pkg::NORMAL_BITS'(qc) : tun_pkg::NORMAL_BITS'(qc);
                if (it_reg[tun_pkg::QW].deg) begin
                    val[j] = '0;
                end
            end
            out_reg.normal_x   <= val[0];
            out_reg.normal_y   <= val[1];
            out_reg.normal_z   <= val[2];
            out_reg.degenerate <= it_reg[tun_pkg::QW].deg;
        end
    end

`ifndef NO_ASSERTIONS
    // degenerate words carry a zero normal
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.normal_x == '0 && m_data.normal_y == '0 && m_data.normal_z == '0)
        else $error("degenerate word with nonzero normal");

    // components stay within +-1.0
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.normal_x <= 16'sd16384 && m_data.normal_x >= -16'sd16384 &&
            m_data.normal_y <= 16'sd16384 && m_data.normal_y >= -16'sd16384 &&
            m_data.normal_z <= 16'sd16384 && m_data.normal_z >= -16'sd16384)
        else $error("normal component out of range");

    // input backpressure only when the pipeline is full and the output stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && (&v_reg))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
